### design/trrb_pkg.sv
// ----------------------------------------------------------------------------
// trrb_pkg
// Shared types and constants of the tcp reset reply builder.
// ----------------------------------------------------------------------------
package trrb_pkg;

    localparam logic [7:0]  FLAG_FIN     = 8'h01;
    localparam logic [7:0]  FLAG_SYN     = 8'h02;
    localparam logic [7:0]  FLAG_RST     = 8'h04;
    localparam logic [7:0]  FLAG_ACK     = 8'h10;
    localparam logic [7:0]  FLAGS_RSTACK = FLAG_RST | FLAG_ACK;

    localparam logic [15:0] PROTO_NUM_TCP = 16'd6;
    localparam logic [15:0] HDR_LEN_BYTES = 16'd20;
    localparam logic [7:0]  DOFF_BYTE     = 8'((HDR_LEN_BYTES / 4) << 4);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // sum of address words, ports, protocol and length
    localparam int PSUM_W = 19;
    // partial sum plus seq, ack and flag word
    localparam int FSUM_W = 20;

    typedef struct packed {
        logic [31:0] in_src_ip;
        logic [31:0] in_dst_ip;
        logic [15:0] in_src_port;
        logic [15:0] in_dst_port;
        logic [31:0] in_seq;
        logic [31:0] in_ack;
        logic [7:0]  in_flags;
        logic [15:0] payload_len;
    } req_t;

    typedef struct packed {
        logic [31:0] out_src_ip;
        logic [31:0] out_dst_ip;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [7:0]  out_flags;
        logic [15:0] out_checksum;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       src_ip;
        logic [31:0]       dst_ip;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [31:0]       seq;
        logic [31:0]       ack;
        logic [7:0]        flags;
        logic [PSUM_W-1:0] part_sum;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### design/trrb_front.sv
// ----------------------------------------------------------------------------
// trrb_front
// Accepts segments, drops those carrying rst, forms reply seq/ack/flags and
// the address, port, protocol and length part of the checksum.
// ----------------------------------------------------------------------------
module trrb_front
    import trrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_t      req,
    input  q_status_t q_status,
    output logic      push,
    output work_t     push_data
);

    logic  valid_reg;
    logic  valid_next;
    work_t work_reg;
    work_t work_next;
    logic  accept;
    logic  has_ack;
    logic  has_syn;
    logic  has_fin;

    assign req_stall = valid_reg && q_status.full;
    assign push      = valid_reg && !q_status.full;
    assign push_data = work_reg;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        has_ack = (req.in_flags & FLAG_ACK) != 8'd0;
        has_syn = (req.in_flags & FLAG_SYN) != 8'd0;
        has_fin = (req.in_flags & FLAG_FIN) != 8'd0;

        work_next.src_ip   = req.in_dst_ip;
        work_next.dst_ip   = req.in_src_ip;
        work_next.src_port = req.in_dst_port;
        work_next.dst_port = req.in_src_port;
        if (has_ack)
        begin
            work_next.seq   = req.in_ack;
            work_next.ack   = 32'd0;
            work_next.flags = FLAG_RST;
        end
        else
        begin
            work_next.seq   = 32'd0;
            work_next.ack   = req.in_seq + 32'(req.payload_len)
                              + 32'(has_syn) + 32'(has_fin);
            work_next.flags = FLAGS_RSTACK;
        end
        work_next.part_sum = PSUM_W'(req.in_src_ip[31:16]) + PSUM_W'(req.in_src_ip[15:0])
                           + PSUM_W'(req.in_dst_ip[31:16]) + PSUM_W'(req.in_dst_ip[15:0])
                           + PSUM_W'(req.in_src_port) + PSUM_W'(req.in_dst_port)
                           + PSUM_W'(PROTO_NUM_TCP) + PSUM_W'(HDR_LEN_BYTES);

        if (accept)
            valid_next = (req.in_flags & FLAG_RST) == 8'd0;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            work_reg <= work_next;
    end

endmodule

### design/trrb_queue.sv
// ----------------------------------------------------------------------------
// trrb_queue
// Short fifo between the front and back parts.
// ----------------------------------------------------------------------------
module trrb_queue
    import trrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  work_t     push_data,
    input  logic      pop,
    output work_t     pop_data,
    output q_status_t q_status
);

    work_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_data       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.empty || q_status.full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

### design/trrb_back.sv
// ----------------------------------------------------------------------------
// trrb_back
// Finishes the checksum and holds the reply in the output register.
// ----------------------------------------------------------------------------
module trrb_back
    import trrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  work_t     pop_data,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_t      rsp
);

    logic              valid_reg;
    logic              valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic [FSUM_W-1:0] full_sum;
    logic [16:0]       fold1;
    logic [15:0]       fold2;

    assign pop       = !q_status.empty && (!valid_reg || !rsp_stall);
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        full_sum = FSUM_W'(pop_data.part_sum)
                 + FSUM_W'(pop_data.seq[31:16]) + FSUM_W'(pop_data.seq[15:0])
                 + FSUM_W'(pop_data.ack[31:16]) + FSUM_W'(pop_data.ack[15:0])
                 + FSUM_W'({DOFF_BYTE, pop_data.flags});
        fold1 = 17'(full_sum[15:0]) + 17'(full_sum[FSUM_W-1:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);

        rsp_next.out_src_ip   = pop_data.src_ip;
        rsp_next.out_dst_ip   = pop_data.dst_ip;
        rsp_next.out_src_port = pop_data.src_port;
        rsp_next.out_dst_port = pop_data.dst_port;
        rsp_next.out_seq      = pop_data.seq;
        rsp_next.out_ack      = pop_data.ack;
        rsp_next.out_flags    = pop_data.flags;
        rsp_next.out_checksum = ~fold2;

        if (pop)
            valid_next = 1'b1;
        else if (!rsp_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_reg <= rsp_next;
    end

endmodule

### design/tcp_reset_reply_builder_top.sv
// path: a request passes the front register, the queue and the output register to its reply
// throughput: one segment per cycle unless rsp_stall backs up the queue; segments carrying rst give no reply
// the two-entry queue lets front and back stall independently
// reset: asynchronous active-low rst_n clears all valid flags and the queue
// ----------------------------------------------------------------------------
// tcp_reset_reply_builder_top
// Builds rst reply headers with checksum for segments matching no connection.
// ----------------------------------------------------------------------------
module tcp_reset_reply_builder_top
    import trrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    q_status_t q_status;
    logic      push;
    work_t     push_data;
    logic      pop;
    work_t     pop_data;

    trrb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    trrb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    trrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_flags_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.out_flags == FLAG_RST || rsp.out_flags == FLAGS_RSTACK))
        else $error("reply flags not rst or rst/ack");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.out_flags == FLAG_RST) |-> rsp.out_ack == 32'd0)
        else $error("rst-only reply with nonzero ack");

    a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.out_flags == FLAGS_RSTACK) |-> rsp.out_seq == 32'd0)
        else $error("rst/ack reply with nonzero seq");
`endif

endmodule

### bench/trrb_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trrb_reply_checker
// Watches the segment and reply channels of the tcp reset reply builder,
// predicts the rst reply for every segment transfer without rst, and compares each reply
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module trrb_reply_checker
    import trrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   replies_checked
);

    rsp_t expected_replies[$];

    function automatic bit build_rst_reply(input req_t seg, output rsp_t reply);
        logic [31:0] seg_len;
        logic [31:0] sum;
        reply = '0;
        if ((seg.in_flags & FLAG_RST) != 0)
            return 1'b0;
        reply.out_src_ip   = seg.in_dst_ip;
        reply.out_dst_ip   = seg.in_src_ip;
        reply.out_src_port = seg.in_dst_port;
        reply.out_dst_port = seg.in_src_port;
        if ((seg.in_flags & FLAG_ACK) != 0)
        begin
            reply.out_seq   = seg.in_ack;
            reply.out_ack   = '0;
            reply.out_flags = FLAG_RST;
        end
        else
        begin
            seg_len = {16'd0, seg.payload_len};
            if ((seg.in_flags & FLAG_SYN) != 0)
                seg_len = seg_len + 32'd1;
            if ((seg.in_flags & FLAG_FIN) != 0)
                seg_len = seg_len + 32'd1;
            reply.out_seq   = '0;
            reply.out_ack   = seg.in_seq + seg_len;
            reply.out_flags = FLAGS_RSTACK;
        end
        // ones' complement sum over pseudo-header and reply header
        sum = 32'(reply.out_src_ip[31:16]) + 32'(reply.out_src_ip[15:0])
            + 32'(reply.out_dst_ip[31:16]) + 32'(reply.out_dst_ip[15:0])
            + 32'(PROTO_NUM_TCP) + 32'(HDR_LEN_BYTES)
            + 32'(reply.out_src_port) + 32'(reply.out_dst_port)
            + 32'(reply.out_seq[31:16]) + 32'(reply.out_seq[15:0])
            + 32'(reply.out_ack[31:16]) + 32'(reply.out_ack[15:0])
            + 32'({DOFF_BYTE, reply.out_flags});
        while (sum[31:16] != 0)
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        reply.out_checksum = ~sum[15:0];
        return 1'b1;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t predicted;
        rsp_t want;
        if (!rst_n)
        begin
            fail_count      = 0;
            pending         = 0;
            replies_checked = 0;
            expected_replies.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (build_rst_reply(req, predicted))
                    expected_replies.push_back(predicted);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply transfer with no segment waiting: %0h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("out_src_ip", want.out_src_ip, rsp.out_src_ip);
                    compare_field("out_dst_ip", want.out_dst_ip, rsp.out_dst_ip);
                    compare_field("out_src_port", 32'(want.out_src_port),
                                  32'(rsp.out_src_port));
                    compare_field("out_dst_port", 32'(want.out_dst_port),
                                  32'(rsp.out_dst_port));
                    compare_field("out_seq", want.out_seq, rsp.out_seq);
                    compare_field("out_ack", want.out_ack, rsp.out_ack);
                    compare_field("out_flags", 32'(want.out_flags), 32'(rsp.out_flags));
                    compare_field("out_checksum", 32'(want.out_checksum),
                                  32'(rsp.out_checksum));
                    replies_checked++;
                end
            end
            pending = expected_replies.size();
        end
    end

endmodule

### bench/tcp_reset_reply_builder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_reset_reply_builder_top_tb
// Drives incoming segments into the rst reply builder: a directed set of
// flag combinations, field extremes, sequence wrap and a zero checksum, then
// random segments over phases of sender idling and receiver stalling. The
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tcp_reset_reply_builder_top_tb;
    import trrb_pkg::*;

    localparam int         CLK_PERIOD         = 4;
    localparam int         RESET_CYCLES       = 11;
    localparam int         WATCHDOG_LIMIT     = 2000;
    localparam int         DRAIN_CYCLES       = 8;
    localparam int         NUM_PHASES         = 4;
    localparam int         REPLIES_PER_PHASE  = 170;
    localparam logic [7:0] FLAG_PSH           = 8'h08;
    localparam logic [7:0] FLAG_URG           = 8'h20;
    localparam logic [7:0] FLAGS_ECN          = 8'hC0;
    localparam int         NUM_FLAG_CASES     = 14;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int pending;
    int replies_checked;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;
    int segments_sent  = 0;
    int rst_segments   = 0;

    int idle_by_phase[NUM_PHASES]  = '{0, 67, 0, 21};
    int stall_by_phase[NUM_PHASES] = '{0, 0, 67, 21};

    logic [7:0] flag_cases[NUM_FLAG_CASES] = '{
        8'h00, FLAG_FIN, FLAG_SYN, FLAG_SYN | FLAG_FIN, FLAG_ACK,
        FLAG_ACK | FLAG_SYN | FLAG_FIN, FLAG_PSH, FLAG_URG, FLAGS_ECN | FLAG_PSH,
        FLAG_RST, FLAGS_RSTACK, FLAG_RST | FLAG_SYN | FLAG_FIN,
        FLAG_ACK | FLAG_PSH | FLAG_URG, ~FLAG_RST
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    tcp_reset_reply_builder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    trrb_reply_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .pending         (pending),
        .replies_checked (replies_checked)
    );

    always @(posedge clk)
    begin
        rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_segment(input req_t seg);
        while ((idle_pct != 0) && ($urandom_range(99) < idle_pct))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= seg;
        do
            @(posedge clk);
        while (req_stall);
        segments_sent++;
        if ((seg.in_flags & FLAG_RST) != 0)
            rst_segments++;
    endtask

    function automatic req_t random_segment();
        req_t seg;
        seg.in_src_ip   = $urandom;
        seg.in_dst_ip   = $urandom;
        seg.in_src_port = 16'($urandom);
        seg.in_dst_port = 16'($urandom);
        seg.in_seq      = $urandom;
        seg.in_ack      = $urandom;
        seg.in_flags    = 8'($urandom_range(255));
        if ($urandom_range(3) != 0)
            seg.in_flags = seg.in_flags & ~FLAG_RST;
        case ($urandom_range(7))
            0: seg.payload_len = 16'd0;
            1: seg.payload_len = 16'hFFFF;
            2: seg.payload_len = 16'($urandom_range(1460));
            default: seg.payload_len = 16'($urandom);
        endcase
        if ($urandom_range(7) == 0)
            seg.in_seq = 32'hFFFF_FFFF - 32'($urandom_range(70000));
        return seg;
    endfunction

    initial
    begin
        req_t seg;
        int   replies_due;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes
        seg = '0;
        send_segment(seg);
        seg = '1;
        seg.in_flags = FLAG_SYN | FLAG_FIN;
        send_segment(seg);
        seg.in_flags = ~FLAG_RST;
        send_segment(seg);
        seg = '1;
        send_segment(seg);

        // every flag combination of interest with random fields
        for (int i = 0; i < NUM_FLAG_CASES; i++)
        begin
            seg = random_segment();
            seg.in_flags = flag_cases[i];
            send_segment(seg);
        end

        // sequence wrap with no payload
        seg = random_segment();
        seg.in_seq      = 32'hFFFF_FFFF;
        seg.payload_len = 16'd0;
        seg.in_flags    = FLAG_SYN;
        send_segment(seg);

        // folded sum of all ones gives a checksum of zero
        seg = '0;
        seg.in_flags = FLAG_ACK;
        seg.in_ack   = 32'h0000_AFE1;
        send_segment(seg);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_pct    = idle_by_phase[phase];
            stall_pct   = stall_by_phase[phase];
            replies_due = 0;
            while (replies_due < REPLIES_PER_PHASE)
            begin
                seg = random_segment();
                send_segment(seg);
                if ((seg.in_flags & FLAG_RST) == 0)
                    replies_due++;
            end
        end

        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("sent %0d segments (%0d carrying rst) over %0d idle/stall phases",
                 segments_sent, rst_segments, NUM_PHASES);
        $display("checked %0d rst replies, %0d mismatches", replies_checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
